FILE: design/qtg_pkg.sv
// Shared types and constants of the quintic trajectory generator.
package qtg_pkg;

	localparam int DataW = 32;
	localparam int StepW = 24;
	localparam int QuoW = 32;
	localparam int CntW = $clog2(QuoW);

	localparam logic [StepW-1:0] TIME_STEP_RESET = 24'd16777;

	typedef enum logic [1:0] {
		PH_READY = 2'd0,
		PH_CALC = 2'd1,
		PH_WORK = 2'd2,
		PH_DONE = 2'd3
	} phase_t;

	typedef struct packed {
		logic start;
		logic [2*DataW-1:0] num_hi;
		logic [DataW-1:0] num_lo;
		logic [2*DataW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
		logic [QuoW-1:0] quo;
	} div_res_t;

endpackage

FILE: design/qtg_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module qtg_mul (
	input logic clk,
	input logic [qtg_pkg::DataW-1:0] a,
	input logic [qtg_pkg::DataW-1:0] b,
	output logic [2*qtg_pkg::DataW-1:0] p
);

	logic [2*qtg_pkg::DataW-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= (2*qtg_pkg::DataW)'(a) * (2*qtg_pkg::DataW)'(b);
	end

	assign p = p_q;

endmodule

FILE: design/qtg_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detection.
module qtg_div (
	input logic clk,
	input logic arst_n,
	input qtg_pkg::div_req_t req,
	output qtg_pkg::div_res_t res
);

	localparam int W = qtg_pkg::DataW;

	logic busy_q, done_q, ovf_q;
	logic [qtg_pkg::CntW-1:0] cnt_q;
	logic [2*W-1:0] rem_q, den_q, rem_n;
	logic [qtg_pkg::QuoW-1:0] lo_q;
	logic [2*W:0] r2;
	logic ge;

	// Shift in the next dividend bit and try the subtraction.
	assign r2 = {rem_q, lo_q[qtg_pkg::QuoW-1]};
	assign ge = r2 >= {1'b0, den_q};
	assign rem_n = ge ? (2*W)'(r2 - {1'b0, den_q}) : r2[2*W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == qtg_pkg::CntW'(qtg_pkg::QuoW - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num_hi;
			lo_q <= req.num_lo;
			den_q <= req.den;
			ovf_q <= req.num_hi >= req.den;
		end else if (busy_q) begin
			rem_q <= rem_n;
			lo_q <= {lo_q[qtg_pkg::QuoW-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.ovf = ovf_q;
	assign res.quo = lo_q;

endmodule

FILE: design/quintic_trajectory_generator.sv
// Top level of the quintic trajectory generator: sequencer, state and result register.
//
// Each request is a tick (op = 0) or a restart (op = 1). Restarts and ticks in
// the ready, calculate and finish phases, and working ticks whose elapsed time
// has reached the latched duration, skip the evaluation and load their result in
// the accept cycle. A working tick that evaluates the quintic runs three
// divisions on the shared bit-serial divider (normalized time, velocity and
// acceleration) plus 17 sequencer steps, mostly on the shared 32 by 32
// multiplier, for the time powers, the squared duration and the span
// products. The block takes one request at a time; the result register holds
// a finished result until it is taken, and the next request is accepted in the
// same cycle that the previous result leaves. Positions are signed Q16.16,
// times unsigned Q8.24 seconds, and all motion outputs saturate to 32 bits.
// The time step register is written through the cfg channel; the user is to
// write it only while the block is idle, which the block itself does not enforce.
module quintic_trajectory_generator (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [qtg_pkg::StepW-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic op,
	input logic signed [qtg_pkg::DataW-1:0] start_position,
	input logic signed [qtg_pkg::DataW-1:0] final_position,
	input logic [qtg_pkg::DataW-1:0] duration,
	output logic out_valid,
	input logic out_ready,
	output logic signed [qtg_pkg::DataW-1:0] position,
	output logic signed [qtg_pkg::DataW-1:0] velocity,
	output logic signed [qtg_pkg::DataW-1:0] acceleration,
	output logic [1:0] phase
);

	localparam int W = qtg_pkg::DataW;
	localparam int CW = 42;
	localparam int MW = 40;
	localparam int AW = 72;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIVU = 5'b00010,
		ST_MULS = 5'b00100,
		ST_DIVV = 5'b01000,
		ST_DIVA = 5'b10000
	} state_t;

	// Multiplier and housekeeping steps of one evaluation.
	localparam logic [4:0] S_U2 = 5'd0;
	localparam logic [4:0] S_U3 = 5'd1;
	localparam logic [4:0] S_U4 = 5'd2;
	localparam logic [4:0] S_U5 = 5'd3;
	localparam logic [4:0] S_TT = 5'd4;
	localparam logic [4:0] S_PLO = 5'd5;
	localparam logic [4:0] S_PHI = 5'd6;
	localparam logic [4:0] S_PSUM = 5'd7;
	localparam logic [4:0] S_POS = 5'd8;
	localparam logic [4:0] S_VLO = 5'd9;
	localparam logic [4:0] S_VHI = 5'd10;
	localparam logic [4:0] S_VSUM = 5'd11;
	localparam logic [4:0] S_VDIV = 5'd12;
	localparam logic [4:0] S_ALO = 5'd13;
	localparam logic [4:0] S_AHI = 5'd14;
	localparam logic [4:0] S_ASUM = 5'd15;
	localparam logic [4:0] S_ADIV = 5'd16;

	state_t state_q;
	logic [4:0] step_q;
	qtg_pkg::phase_t phase_q;
	logic [qtg_pkg::StepW-1:0] ts_q;
	logic signed [W-1:0] start_q, end_q;
	logic [W-1:0] dur_q, elapsed_q;
	logic signed [W-1:0] pos_q, vel_q, acc_q;
	logic out_valid_q;

	logic [W-1:0] span_mag_q;
	logic span_neg_q;
	logic [W-1:0] u1_q, u2_q, u3_q, u4_q, u5_q;
	logic [2*W-1:0] tt_q;
	logic [MW-1:0] cmag_q;
	logic cneg_q;
	logic [AW-1:0] macc_q;
	logic sneg_q;
	logic [W-1:0] posn_q, veln_q;
	logic fin_q;

	logic in_acc;
	logic eval_go;
	logic res_set;
	logic [W:0] nxt;
	logic fin;
	logic signed [W:0] span;
	logic [W-1:0] mul_a, mul_b;
	logic [2*W-1:0] mul_p;
	qtg_pkg::div_req_t div_req;
	qtg_pkg::div_res_t div_res;
	logic signed [CW-1:0] e1, e2, e3, e4, e5;
	logic signed [CW-1:0] c_pos, c_vel, c_acc, c_sel;
	logic [CW-1:0] c_abs;
	logic signed [CW-1:0] off, pos_sum;
	logic [W-1:0] pos_sat;
	logic prod_neg;

	// Saturate a quotient magnitude with its sign into a signed 32-bit value.
	function automatic logic [W-1:0] sat_quo(input logic [W-1:0] q, input logic ovf,
			input logic neg);
		logic [W-1:0] r;
		if (neg) begin
			if (ovf || q > {1'b1, {(W-1){1'b0}}})
				r = {1'b1, {(W-1){1'b0}}};
			else
				r = W'(-q);
		end else begin
			if (ovf || q > {1'b0, {(W-1){1'b1}}})
				r = {1'b0, {(W-1){1'b1}}};
			else
				r = q;
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign position = pos_q;
	assign velocity = vel_q;
	assign acceleration = acc_q;
	assign phase = phase_q;

	// Elapsed time after this tick, compared live against the duration input.
	assign nxt = {1'b0, elapsed_q} + (W+1)'(ts_q);
	assign fin = nxt >= {1'b0, duration};
	assign span = $signed({final_position[W-1], final_position})
		- $signed({start_position[W-1], start_position});

	// A working tick with elapsed time still below the latched duration needs
	// the full evaluation; everything else finishes in the accept cycle.
	assign eval_go = in_acc && !op && (phase_q == qtg_pkg::PH_WORK) && (elapsed_q < dur_q);

	// A result is loaded by every request that skips the evaluation and by the
	// end of the last division.
	assign res_set = (in_acc && !eval_go) || (state_q == ST_DIVA && div_res.done);

	// Polynomial combinations of the normalized time powers. Multiplying them
	// by the span gives the exact numerators of the three motion outputs.
	assign e1 = $signed(CW'(u1_q));
	assign e2 = $signed(CW'(u2_q));
	assign e3 = $signed(CW'(u3_q));
	assign e4 = $signed(CW'(u4_q));
	assign e5 = $signed(CW'(u5_q));
	assign c_pos = 42'sd10 * e3 - 42'sd15 * e4 + 42'sd6 * e5;
	assign c_vel = 42'sd30 * e2 - 42'sd60 * e3 + 42'sd30 * e4;
	assign c_acc = 42'sd60 * e1 - 42'sd180 * e2 + 42'sd120 * e3;

	always_comb begin
		case (step_q)
			S_TT: c_sel = c_pos;
			S_POS: c_sel = c_vel;
			default: c_sel = c_acc;
		endcase
	end

	assign c_abs = c_sel[CW-1] ? CW'(-c_sel) : CW'(c_sel);
	assign prod_neg = span_neg_q ^ cneg_q;

	// Position: start plus the signed upper part of the span product.
	assign off = $signed({2'b00, macc_q[AW-1:W]});
	assign pos_sum = $signed({{(CW-W){start_q[W-1]}}, start_q}) + (prod_neg ? -off : off);
	always_comb begin
		if (pos_sum > $signed(CW'({1'b0, {(W-1){1'b1}}})))
			pos_sat = {1'b0, {(W-1){1'b1}}};
		else if (pos_sum < -$signed(CW'({1'b1, {(W-1){1'b0}}})))
			pos_sat = {1'b1, {(W-1){1'b0}}};
		else
			pos_sat = pos_sum[W-1:0];
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = span_mag_q;
		mul_b = cmag_q[W-1:0];
		if (state_q == ST_DIVU) begin
			mul_a = div_res.quo;
			mul_b = div_res.quo;
		end else begin
			case (step_q)
				S_U2, S_U3, S_U4: begin
					mul_a = mul_p[2*W-1:W];
					mul_b = u1_q;
				end
				S_U5: begin
					mul_a = dur_q;
					mul_b = dur_q;
				end
				S_PHI, S_VHI, S_AHI: begin
					mul_b = W'(cmag_q[MW-1:W]);
				end
				default: begin
					mul_b = cmag_q[W-1:0];
				end
			endcase
		end
	end

	// Divider requests: normalized time, velocity and acceleration.
	always_comb begin
		div_req.start = eval_go;
		div_req.num_hi = {{W{1'b0}}, elapsed_q};
		div_req.num_lo = '0;
		div_req.den = {{W{1'b0}}, dur_q};
		if (state_q == ST_MULS && step_q == S_VDIV) begin
			div_req.start = 1'b1;
			div_req.num_hi = (2*W)'(macc_q[AW-1:W+8]);
			div_req.num_lo = macc_q[W+7:8];
		end else if (state_q == ST_MULS && step_q == S_ADIV) begin
			div_req.start = 1'b1;
			div_req.num_hi = (2*W)'(macc_q[AW-1:16]);
			div_req.num_lo = {macc_q[15:0], 16'b0};
			div_req.den = tt_q;
		end
	end

	qtg_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.p(mul_p)
	);

	qtg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.res(div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= S_U2;
			phase_q <= qtg_pkg::PH_READY;
			ts_q <= qtg_pkg::TIME_STEP_RESET;
			start_q <= '0;
			end_q <= '0;
			dur_q <= '0;
			elapsed_q <= '0;
			pos_q <= '0;
			vel_q <= '0;
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				ts_q <= cfg_data;
			if (res_set)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (op) begin
							phase_q <= qtg_pkg::PH_READY;
						end else begin
							unique case (phase_q)
								qtg_pkg::PH_READY: begin
									phase_q <= qtg_pkg::PH_CALC;
								end
								qtg_pkg::PH_CALC: begin
									start_q <= start_position;
									end_q <= final_position;
									dur_q <= duration;
									elapsed_q <= '0;
									phase_q <= qtg_pkg::PH_WORK;
								end
								qtg_pkg::PH_WORK: begin
									elapsed_q <= nxt[W] ? '1 : nxt[W-1:0];
									if (eval_go) begin
										state_q <= ST_DIVU;
									end else begin
										pos_q <= end_q;
										vel_q <= '0;
										acc_q <= '0;
										if (fin)
											phase_q <= qtg_pkg::PH_DONE;
									end
								end
								default: begin
									vel_q <= '0;
									acc_q <= '0;
									start_q <= end_q;
								end
							endcase
						end
					end
				end
				ST_DIVU: begin
					if (div_res.done) begin
						step_q <= S_U2;
						state_q <= ST_MULS;
					end
				end
				ST_MULS: begin
					step_q <= step_q + 1'b1;
					if (step_q == S_VDIV)
						state_q <= ST_DIVV;
					else if (step_q == S_ADIV)
						state_q <= ST_DIVA;
				end
				ST_DIVV: begin
					if (div_res.done) begin
						step_q <= S_ALO;
						state_q <= ST_MULS;
					end
				end
				ST_DIVA: begin
					if (div_res.done) begin
						pos_q <= fin_q ? end_q : posn_q;
						vel_q <= veln_q;
						acc_q <= sat_quo(div_res.quo, div_res.ovf, sneg_q);
						if (fin_q)
							phase_q <= qtg_pkg::PH_DONE;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the evaluation sequence.
	always_ff @(posedge clk) begin
		if (in_acc && !op && phase_q == qtg_pkg::PH_CALC) begin
			span_neg_q <= span[W];
			span_mag_q <= span[W] ? W'(-span) : W'(span);
		end
		if (eval_go)
			fin_q <= fin;
		if (state_q == ST_DIVU && div_res.done)
			u1_q <= div_res.quo;
		if (state_q == ST_DIVV && div_res.done)
			veln_q <= sat_quo(div_res.quo, div_res.ovf, sneg_q);
		if (state_q == ST_MULS) begin
			case (step_q)
				S_U2: u2_q <= mul_p[2*W-1:W];
				S_U3: u3_q <= mul_p[2*W-1:W];
				S_U4: u4_q <= mul_p[2*W-1:W];
				S_U5: u5_q <= mul_p[2*W-1:W];
				S_TT: begin
					tt_q <= mul_p;
					cmag_q <= c_abs[MW-1:0];
					cneg_q <= c_sel[CW-1];
				end
				S_PHI, S_VHI, S_AHI: macc_q <= AW'(mul_p);
				S_PSUM, S_VSUM, S_ASUM: macc_q <= macc_q + {mul_p[AW-W-1:0], {W{1'b0}}};
				S_POS: begin
					posn_q <= pos_sat;
					cmag_q <= c_abs[MW-1:0];
					cneg_q <= c_sel[CW-1];
				end
				S_VDIV: begin
					sneg_q <= prod_neg;
					cmag_q <= c_abs[MW-1:0];
					cneg_q <= c_sel[CW-1];
				end
				S_ADIV: sneg_q <= prod_neg;
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// No result may be pending while an evaluation runs.
	a_eval_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !out_valid_q)
		else $error("result pending during evaluation");

	// The divider only finishes while the sequencer waits for it.
	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIVU || state_q == ST_DIVV || state_q == ST_DIVA))
		else $error("divider finished outside a wait state");

	// An evaluation only runs in the working phase.
	a_eval_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVU) |-> (phase_q == qtg_pkg::PH_WORK))
		else $error("evaluation outside working phase");
`endif

endmodule

FILE: dv/tb_quintic_trajectory_generator.sv
// Self-checking testbench for the quintic trajectory generator.
module tb_quintic_trajectory_generator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IdleLimit = 5000;
	localparam int DrainCycles = 200;
	localparam int ItemsPerSetting = 270;

	typedef struct {
		logic [31:0] pos;
		logic [31:0] vel;
		logic [31:0] acc;
		qtg_pkg::phase_t ph;
	} motion_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [qtg_pkg::StepW-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic op;
	logic signed [qtg_pkg::DataW-1:0] start_position;
	logic signed [qtg_pkg::DataW-1:0] final_position;
	logic [qtg_pkg::DataW-1:0] duration;
	logic out_valid;
	logic out_ready;
	logic signed [qtg_pkg::DataW-1:0] position;
	logic signed [qtg_pkg::DataW-1:0] velocity;
	logic signed [qtg_pkg::DataW-1:0] acceleration;
	logic [1:0] phase;

	quintic_trajectory_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.start_position(start_position),
		.final_position(final_position),
		.duration(duration),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.position(position),
		.velocity(velocity),
		.acceleration(acceleration),
		.phase(phase)
	);

	// Predicted state of the trajectory generator.
	logic [23:0] step_q;
	qtg_pkg::phase_t ph_q;
	logic [31:0] start_q, end_q, dur_q, elapsed_q;
	longint c3_q, c4_q, c5_q;
	logic [31:0] pos_q, vel_q, acc_q;

	motion_t pending_motion[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet = 0; // When set, neither side inserts wait cycles.

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Saturate a magnitude with a sign to the signed 32-bit range.
	function automatic logic [31:0] sat_mag(logic [127:0] mag, bit neg);
		if (neg) begin
			if (mag > 128'h8000_0000)
				return 32'h8000_0000;
			return 32'(-mag[31:0]);
		end
		if (mag > 128'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	// Advance the predicted state by one request and queue the expected result.
	function automatic void predict_motion(bit o, logic [31:0] s, logic [31:0] f, logic [31:0] d);
		logic [63:0] u1, u2, u3, u4, u5, t64, d64;
		logic signed [127:0] sum;
		logic [127:0] mag;
		logic [32:0] nxt;
		longint span, p64, off;
		bit neg;
		motion_t m;
		if (o) begin
			ph_q = qtg_pkg::PH_READY;
		end else begin
			case (ph_q)
				qtg_pkg::PH_READY: begin
					ph_q = qtg_pkg::PH_CALC;
				end
				qtg_pkg::PH_CALC: begin
					start_q = s;
					end_q = f;
					dur_q = d;
					elapsed_q = '0;
					span = longint'($signed(f)) - longint'($signed(s));
					c3_q = 10 * span;
					c4_q = -15 * span;
					c5_q = 6 * span;
					ph_q = qtg_pkg::PH_WORK;
				end
				qtg_pkg::PH_WORK: begin
					if (elapsed_q >= dur_q) begin
						// Elapsed time has already reached the latched duration.
						pos_q = end_q;
						vel_q = '0;
						acc_q = '0;
					end else begin
						t64 = {32'b0, elapsed_q};
						d64 = {32'b0, dur_q};
						u1 = (t64 << 32) / d64;
						u2 = (u1 * u1) >> 32;
						u3 = (u2 * u1) >> 32;
						u4 = (u3 * u1) >> 32;
						u5 = (u4 * u1) >> 32;

						sum = 128'(c3_q) * $signed({64'b0, u3}) + 128'(c4_q) * $signed({64'b0, u4})
							+ 128'(c5_q) * $signed({64'b0, u5});
						neg = sum[127];
						mag = neg ? 128'(-sum) : 128'(sum);
						mag = mag >> 32;
						off = (mag > (128'd1 << 40)) ? (longint'(1) << 40) : longint'(mag[63:0]);
						p64 = longint'($signed(start_q)) + (neg ? -off : off);
						if (p64 > 64'sh7FFF_FFFF)
							pos_q = 32'h7FFF_FFFF;
						else if (p64 < -64'sh8000_0000)
							pos_q = 32'h8000_0000;
						else
							pos_q = p64[31:0];

						sum = 128'(3 * c3_q) * $signed({64'b0, u2})
							+ 128'(4 * c4_q) * $signed({64'b0, u3})
							+ 128'(5 * c5_q) * $signed({64'b0, u4});
						neg = sum[127];
						mag = neg ? 128'(-sum) : 128'(sum);
						mag = (mag >> 8) / {96'b0, dur_q};
						vel_q = sat_mag(mag, neg);

						sum = 128'(6 * c3_q) * $signed({64'b0, u1})
							+ 128'(12 * c4_q) * $signed({64'b0, u2})
							+ 128'(20 * c5_q) * $signed({64'b0, u3});
						neg = sum[127];
						mag = neg ? 128'(-sum) : 128'(sum);
						mag = ((mag << 16) / {96'b0, dur_q}) / {96'b0, dur_q};
						acc_q = sat_mag(mag, neg);
					end
					// The end test uses the live duration field, not the latched one.
					nxt = {1'b0, elapsed_q} + {9'b0, step_q};
					elapsed_q = nxt[32] ? 32'hFFFF_FFFF : nxt[31:0];
					if (nxt >= {1'b0, d}) begin
						pos_q = end_q;
						ph_q = qtg_pkg::PH_DONE;
					end
				end
				default: begin
					vel_q = '0;
					acc_q = '0;
					start_q = end_q;
				end
			endcase
		end
		m.pos = pos_q;
		m.vel = vel_q;
		m.acc = acc_q;
		m.ph = ph_q;
		pending_motion.push_back(m);
	endfunction

	// Present one request, hold it until it is taken, then predict its result.
	task automatic send_req(bit o, logic [31:0] s, logic [31:0] f, logic [31:0] d);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (gap) @(negedge clk);
		op = o;
		start_position = s;
		final_position = f;
		duration = d;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		predict_motion(o, s, f, d);
	endtask

	// Wait until every outstanding result has been taken and checked.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		wait (pending_motion.size() == 0);
		repeat (4) @(negedge clk);
	endtask

	// Write the time step register; only called while the block is drained.
	task automatic write_step(logic [23:0] value);
		@(negedge clk);
		cfg_data = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		step_q = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Receiver: stall a random number of cycles before each result.
	initial begin
		int stall;
		out_ready = 1'b0;
		forever begin
			stall = quiet ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result with the oldest prediction, field by field.
	always @(posedge clk) begin
		motion_t m;
		if (arst_n && out_valid && out_ready) begin
			if (pending_motion.size() == 0) begin
				$display("%0t: unexpected result pos=%h vel=%h acc=%h phase=%0d",
					$time, position, velocity, acceleration, phase);
				errors++;
			end else begin
				m = pending_motion.pop_front();
				if (position !== m.pos) begin
					$display("%0t: position expected %h actual %h", $time, m.pos, position);
					errors++;
				end
				if (velocity !== m.vel) begin
					$display("%0t: velocity expected %h actual %h", $time, m.vel, velocity);
					errors++;
				end
				if (acceleration !== m.acc) begin
					$display("%0t: acceleration expected %h actual %h",
						$time, m.acc, acceleration);
					errors++;
				end
				if (phase !== m.ph) begin
					$display("%0t: phase expected %0d actual %0d", $time, m.ph, phase);
					errors++;
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on any channel is a hang.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// One complete move: restart, leave ready, latch the move, then tick until
	// it finishes or max_ticks ticks are sent, then send up to three more ticks.
	task automatic run_move(logic [31:0] s, logic [31:0] f, logic [31:0] d, int max_ticks);
		int n;
		logic [31:0] live;
		send_req(1'b1, $urandom, $urandom, $urandom);
		send_req(1'b0, $urandom, $urandom, $urandom);
		send_req(1'b0, s, f, d);
		n = 0;
		while (ph_q == qtg_pkg::PH_WORK && n < max_ticks) begin
			// Mostly the same duration; sometimes a different live one.
			live = ($urandom_range(0, 15) == 0) ? 32'($urandom) : d;
			send_req(1'b0, $urandom, $urandom, live);
			n++;
		end
		repeat ($urandom_range(0, 3)) send_req(1'b0, $urandom, $urandom, $urandom);
	endtask

	task automatic test_directed();
		// A tick straight out of reset with the held zero outputs.
		send_req(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
		// Restart from calculate goes back to ready.
		send_req(1'b1, 32'h0, 32'h0, 32'h1);
		send_req(1'b0, 32'h0, 32'h0, 32'h1);
		// Zero latched duration: the first working tick lands on the end.
		send_req(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
		send_req(1'b0, 32'h0, 32'h0, 32'h0);
		// Finish ticks zero the derivatives and hold the end.
		send_req(1'b0, 32'h0, 32'h0, 32'h0);
		send_req(1'b0, 32'h0, 32'h0, 32'h0);
		// Full-range move with a short duration drives velocity and acceleration into saturation.
		run_move(32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000, 6);
		// Reverse full-range move.
		run_move(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 6);
		// Restart in the middle of a move.
		send_req(1'b1, 32'h0, 32'h0, 32'h0);
		send_req(1'b0, 32'h0, 32'h0, 32'h0);
		send_req(1'b0, 32'h0, 32'h0064_0000, 32'h0004_0000);
		send_req(1'b0, 32'h0, 32'h0, 32'h0004_0000);
		send_req(1'b1, 32'h0, 32'h0, 32'h0);
		// Live duration bigger than the latched one: elapsed passes the latched end.
		send_req(1'b0, 32'h0, 32'h0, 32'h0);
		send_req(1'b0, 32'h0, 32'h0010_0000, 32'h0000_8000);
		send_req(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_req(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_random_moves(int count);
		int sent;
		longint k, d;
		logic [31:0] s, f;
		sent = 0;
		while (sent < count) begin
			quiet = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				// Noise: arbitrary requests in whatever phase the block is in.
				repeat (4) send_req(1'(($urandom_range(0, 5) == 0)), $urandom, $urandom, $urandom);
				sent += 4;
			end else begin
				k = $urandom_range(1, 12);
				d = k * longint'(step_q) - (($urandom_range(0, 1) == 1) ?
					$urandom_range(0, step_q - 1) : 0);
				if ($urandom_range(0, 7) == 0)
					d = {$urandom, $urandom} & 64'hFFFF_FFFF;
				if (d > 64'hFFFF_FFFF)
					d = 64'hFFFF_FFFF;
				if (d == 0)
					d = 1;
				case ($urandom_range(0, 5))
					0: begin
						s = 32'h8000_0000;
						f = 32'h7FFF_FFFF;
					end
					1: begin
						s = 32'h7FFF_FFFF;
						f = 32'h8000_0000;
					end
					2: begin
						s = $urandom_range(0, 32'h00FF_FFFF);
						f = s + $urandom_range(0, 32'h000F_FFFF);
					end
					default: begin
						s = $urandom;
						f = $urandom;
					end
				endcase
				run_move(s, f, d[31:0], 16);
				sent += 4 + int'(k);
			end
		end
		quiet = 0;
		drain();
	endtask

	task automatic test_step_settings();
		// Reset value first, then both extremes and a few others.
		test_random_moves(ItemsPerSetting);
		write_step(24'd1);
		test_random_moves(ItemsPerSetting);
		write_step(24'hFF_FFFF);
		test_random_moves(ItemsPerSetting);
		write_step(24'($urandom_range(1, 24'hFF_FFFF)));
		test_random_moves(ItemsPerSetting);
		write_step(24'($urandom_range(1, 24'h00_FFFF)));
		test_random_moves(ItemsPerSetting);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = 1'b0;
		start_position = '0;
		final_position = '0;
		duration = '0;
		step_q = qtg_pkg::TIME_STEP_RESET;
		ph_q = qtg_pkg::PH_READY;
		start_q = '0;
		end_q = '0;
		dur_q = '0;
		elapsed_q = '0;
		c3_q = 0;
		c4_q = 0;
		c5_q = 0;
		pos_q = '0;
		vel_q = '0;
		acc_q = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_step_settings();

		repeat (DrainCycles) @(negedge clk);
		if (errors == 0 && pending_motion.size() == 0) begin
			$display("PASS");
		end else begin
			if (pending_motion.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_motion.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule
